>>> rtl/forb_pkg.sv
package forb_pkg;

    // Header word layout
    localparam int unsigned HdrCompBit  = 31;
    localparam int unsigned HdrBaseBit  = 30;
    localparam int unsigned HdrWidthLsb = 27;
    localparam int unsigned LenWidth    = 23;

    // Base sizes in bytes for narrow and wide values
    localparam logic [LenWidth-1:0] BaseSzNarrow = LenWidth'(4);
    localparam logic [LenWidth-1:0] BaseSzWide   = LenWidth'(8);

    // Last base byte index for narrow and wide values
    localparam logic [2:0] BaseLastNarrow = 3'd3;
    localparam logic [2:0] BaseLastWide   = 3'd7;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BASE   = 2'd1,
        PH_DATA   = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SKIPPED   = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    typedef struct packed {
        t_phase               phase;
        logic [2:0]           byte_index;
        logic [31:0]          header_word;
        logic [63:0]          base_value;
        logic [63:0]          partial_value;
        logic [LenWidth-1:0]  bytes_left;
        logic [3:0]           bytes_per_value;
    } t_state;

    // Parser state after reset: waiting for a header, one byte per value
    localparam t_state StateReset = '{
        phase:           PH_HEADER,
        byte_index:      3'd0,
        header_word:     32'd0,
        base_value:      64'd0,
        partial_value:   64'd0,
        bytes_left:      '0,
        bytes_per_value: 4'd1
    };

    typedef struct packed {
        logic        valid;
        logic [63:0] value;
        logic        has_value;
        logic        block_end;
        t_status     status;
    } t_result;

endpackage

>>> rtl/frame_of_reference_byte_unpack_decoder.sv
// Frame-of-reference byte-packed block decoder.
// Input channel: one stream byte per item on i_data_byte, taken when i_valid
// is high and o_stall is low. Output channel: one result item (o_value,
// o_has_value, o_block_end, o_status) offered on o_valid, taken when i_stall
// is low. Header, base and skipped bytes give no result, except the byte
// that closes a block.
// Configuration: i_cfg_data[0] selects 64-bit (1) or 32-bit (0) values; it is
// written when i_cfg_valid and o_cfg_ready are high, and o_cfg_ready is
// always high. Write it only while the block is idle.
// Timing: a result appears on o_valid in the cycle after the byte that causes
// it is taken. Throughput: one byte per cycle while o_stall is low; the parser
// step (byte merge, 64-bit base add and length count) sits between the parser
// state register and the result register.
// Stalls: while a result waits with i_stall high, o_stall is raised and no
// byte is taken; the result holds until taken.
// Reset (synchronous, i_rst_n low): parser waits for a header, no result
// pending, value width set to 64 bits.
module frame_of_reference_byte_unpack_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value,
    output logic        o_has_value,
    output logic        o_block_end,
    output logic [1:0]  o_status,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    forb_pkg::t_state  r_state;
    forb_pkg::t_state  n_state;
    forb_pkg::t_result w_result;
    forb_pkg::t_result r_out;
    logic              r_wide;
    logic              w_in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out.valid & i_stall;
    assign w_in_acc    = i_valid & ~o_stall;

    forb_step u_step (
        .i_state  (r_state),
        .i_byte   (i_data_byte),
        .i_wide   (r_wide),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // Value width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wide <= i_cfg_data;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= forb_pkg::StateReset;
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (w_in_acc) begin
            r_out <= w_result;
        end else if (!i_stall) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_valid     = r_out.valid;
    assign o_value     = r_out.value;
    assign o_has_value = r_out.has_value;
    assign o_block_end = r_out.block_end;
    assign o_status    = r_out.status;

endmodule

>>> rtl/forb_step.sv
module forb_step (
    input  forb_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_wide,
    output forb_pkg::t_state  o_state,
    output forb_pkg::t_result o_result
);

    logic [63:0]                   w_byte_at;
    logic [31:0]                   w_hdr_ext;
    logic [31:0]                   w_hdr;
    logic [forb_pkg::LenWidth-1:0] w_len;
    logic [forb_pkg::LenWidth-1:0] w_sz;
    logic [forb_pkg::LenWidth-1:0] w_left_dec;
    logic [63:0]                   w_partial;
    logic [63:0]                   w_sum;
    logic                          w_comp;
    logic                          w_last_of_value;

    // Byte placed at its little-endian lane
    always_comb begin
        w_byte_at = 64'(i_byte) << {i_state.byte_index, 3'b000};
        w_hdr_ext = 32'(i_byte) << {i_state.byte_index[1:0], 3'b000};
    end

    always_comb begin
        w_hdr      = i_state.header_word | w_hdr_ext;
        w_len      = w_hdr[forb_pkg::LenWidth-1:0];
        w_sz       = i_wide ? forb_pkg::BaseSzWide : forb_pkg::BaseSzNarrow;
        w_left_dec = (i_state.bytes_left != '0) ? i_state.bytes_left - 1'b1
                                                : i_state.bytes_left;
        w_partial  = i_state.partial_value | w_byte_at;
        w_sum      = w_partial + i_state.base_value;
        w_comp     = (i_state.phase == forb_pkg::PH_HEADER)
                   ? w_hdr[forb_pkg::HdrCompBit]
                   : i_state.header_word[forb_pkg::HdrCompBit];
        w_last_of_value = ({1'b0, i_state.byte_index} + 4'd1)
                          >= i_state.bytes_per_value;
    end

    // One byte step of the block parser
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_state.phase)
            forb_pkg::PH_HEADER: begin
                o_state.header_word = w_hdr;
                if (i_state.byte_index < 3'd3) begin
                    o_state.byte_index = i_state.byte_index + 3'd1;
                end else begin
                    o_state.byte_index      = '0;
                    o_state.bytes_per_value = 4'd1 + {1'b0, w_hdr[forb_pkg::HdrWidthLsb +: 3]};
                    o_state.base_value      = '0;
                    o_state.partial_value   = '0;
                    if (w_hdr[forb_pkg::HdrBaseBit]) begin
                        o_state.bytes_left = (w_len > w_sz) ? w_len - w_sz : '0;
                        o_state.phase      = forb_pkg::PH_BASE;
                    end else begin
                        o_state.bytes_left = w_len;
                        o_state.phase = w_comp ? forb_pkg::PH_SKIP : forb_pkg::PH_DATA;
                        // empty body closes the block at once
                        if (w_len == '0) begin
                            o_state.phase       = forb_pkg::PH_HEADER;
                            o_state.header_word = '0;
                            o_result.valid      = 1'b1;
                            o_result.block_end  = 1'b1;
                            o_result.status     = w_comp ? forb_pkg::ST_SKIPPED
                                                         : forb_pkg::ST_OK;
                        end
                    end
                end
            end
            forb_pkg::PH_BASE: begin
                o_state.base_value = i_state.base_value | w_byte_at;
                if (i_state.byte_index >= (i_wide ? forb_pkg::BaseLastWide
                                                  : forb_pkg::BaseLastNarrow)) begin
                    o_state.byte_index    = '0;
                    o_state.partial_value = '0;
                    o_state.phase = w_comp ? forb_pkg::PH_SKIP : forb_pkg::PH_DATA;
                    if (i_state.bytes_left == '0) begin
                        o_state.phase       = forb_pkg::PH_HEADER;
                        o_state.header_word = '0;
                        o_result.valid      = 1'b1;
                        o_result.block_end  = 1'b1;
                        o_result.status     = w_comp ? forb_pkg::ST_SKIPPED
                                                     : forb_pkg::ST_OK;
                    end
                end else begin
                    o_state.byte_index = i_state.byte_index + 3'd1;
                end
            end
            forb_pkg::PH_DATA: begin
                o_state.bytes_left = w_left_dec;
                if (w_last_of_value) begin
                    o_state.byte_index    = '0;
                    o_state.partial_value = '0;
                    o_result.valid        = 1'b1;
                    o_result.has_value    = 1'b1;
                    o_result.value        = i_wide ? w_sum : {32'd0, w_sum[31:0]};
                    o_result.status       = forb_pkg::ST_OK;
                    if (w_left_dec == '0) begin
                        o_state.phase       = forb_pkg::PH_HEADER;
                        o_state.header_word = '0;
                        o_result.block_end  = 1'b1;
                    end
                end else begin
                    o_state.byte_index    = i_state.byte_index + 3'd1;
                    o_state.partial_value = w_partial;
                    // block ends inside a value
                    if (w_left_dec == '0) begin
                        o_state.phase         = forb_pkg::PH_HEADER;
                        o_state.header_word   = '0;
                        o_state.byte_index    = '0;
                        o_state.partial_value = '0;
                        o_result.valid        = 1'b1;
                        o_result.block_end    = 1'b1;
                        o_result.status       = forb_pkg::ST_TRUNCATED;
                    end
                end
            end
            default: begin
                o_state.bytes_left = w_left_dec;
                if (w_left_dec == '0) begin
                    o_state.phase         = forb_pkg::PH_HEADER;
                    o_state.header_word   = '0;
                    o_state.byte_index    = '0;
                    o_state.partial_value = '0;
                    o_result.valid        = 1'b1;
                    o_result.block_end    = 1'b1;
                    o_result.status       = forb_pkg::ST_SKIPPED;
                end
            end
        endcase
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE      = 8;
    localparam int TIMEOUT_NS  = 2_000_000;

    // DUT ports
    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [63:0] o_value;
    logic        o_has_value;
    logic        o_block_end;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data  = 1'b0;

    frame_of_reference_byte_unpack_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_has_value (o_has_value),
        .o_block_end (o_block_end),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Stream bytes waiting to be offered, and decoded results still owed
    logic [7:0]        byte_q[$];
    forb_pkg::t_result result_q[$];

    // Traffic shaping
    int  idle_pct  = 0;
    int  stall_pct = 0;
    bit  hold_go   = 1'b0;
    logic rx_hold  = 1'b0;

    // Bookkeeping
    int bytes_queued = 0;
    int bytes_taken  = 0;
    int mismatches   = 0;
    int n_results    = 0;
    int n_values     = 0;
    int n_blocks     = 0;
    int n_skipped    = 0;
    int n_truncated  = 0;
    int n_width_sets = 0;

    // Decoder state as predicted
    forb_pkg::t_phase              ph       = forb_pkg::PH_HEADER;
    logic [2:0]                    idx      = '0;
    logic [31:0]                   hdr      = '0;
    logic [63:0]                   base_acc = '0;
    logic [63:0]                   part_acc = '0;
    logic [forb_pkg::LenWidth-1:0] left     = '0;
    logic [3:0]                    bpv      = 4'd1;
    logic                          wide     = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void close_block();
        ph       = forb_pkg::PH_HEADER;
        hdr      = '0;
        idx      = '0;
        part_acc = '0;
    endfunction

    // Start of payload; an empty body closes the block straight away
    function automatic forb_pkg::t_result open_body();
        forb_pkg::t_result r;
        r        = '0;
        idx      = '0;
        part_acc = '0;
        ph       = hdr[forb_pkg::HdrCompBit] ? forb_pkg::PH_SKIP : forb_pkg::PH_DATA;
        if (left == '0) begin
            r.valid     = 1'b1;
            r.block_end = 1'b1;
            r.status    = hdr[forb_pkg::HdrCompBit] ? forb_pkg::ST_SKIPPED : forb_pkg::ST_OK;
            close_block();
        end
        return r;
    endfunction

    function automatic forb_pkg::t_result decode_byte(input logic [7:0] b);
        forb_pkg::t_result             r;
        logic [forb_pkg::LenWidth-1:0] len;
        logic [forb_pkg::LenWidth-1:0] bsz;
        r = '0;
        case (ph)
            forb_pkg::PH_HEADER: begin
                hdr = hdr | (32'(b) << (8 * idx[1:0]));
                if (idx < 3'd3) begin
                    idx = idx + 3'd1;
                end else begin
                    idx      = '0;
                    len      = hdr[forb_pkg::LenWidth-1:0];
                    bpv      = 4'd1 + 4'(hdr[forb_pkg::HdrWidthLsb +: 3]);
                    base_acc = '0;
                    part_acc = '0;
                    if (hdr[forb_pkg::HdrBaseBit]) begin
                        // base size follows the current width; length saturates
                        bsz  = wide ? forb_pkg::BaseSzWide : forb_pkg::BaseSzNarrow;
                        left = (len > bsz) ? len - bsz : '0;
                        ph   = forb_pkg::PH_BASE;
                    end else begin
                        left = len;
                        r    = open_body();
                    end
                end
            end
            forb_pkg::PH_BASE: begin
                base_acc = base_acc | (64'(b) << (8 * idx));
                if (idx >= (wide ? forb_pkg::BaseLastWide : forb_pkg::BaseLastNarrow))
                    r = open_body();
                else
                    idx = idx + 3'd1;
            end
            forb_pkg::PH_DATA: begin
                part_acc = part_acc | (64'(b) << (8 * idx));
                if (left != '0)
                    left = left - 1'b1;
                if ({1'b0, idx} + 4'd1 >= bpv) begin
                    r.valid     = 1'b1;
                    r.has_value = 1'b1;
                    r.value     = (part_acc + base_acc) & {{32{wide}}, 32'hFFFF_FFFF};
                    r.block_end = (left == '0);
                    r.status    = forb_pkg::ST_OK;
                    idx         = '0;
                    part_acc    = '0;
                    if (r.block_end)
                        close_block();
                end else begin
                    idx = idx + 3'd1;
                    // block ran out partway through a value
                    if (left == '0) begin
                        r.valid     = 1'b1;
                        r.block_end = 1'b1;
                        r.status    = forb_pkg::ST_TRUNCATED;
                        close_block();
                    end
                end
            end
            default: begin
                if (left != '0)
                    left = left - 1'b1;
                if (left == '0) begin
                    r.valid     = 1'b1;
                    r.block_end = 1'b1;
                    r.status    = forb_pkg::ST_SKIPPED;
                    close_block();
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: predicts on every accepted item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        forb_pkg::t_result r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                bytes_taken++;
                r = decode_byte(i_data_byte);
                if (r.valid)
                    result_q.push_back(r);
            end
            if (!i_valid || !o_stall) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_valid     <= 1'b1;
                    i_data_byte <= byte_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall
    // ------------------------------------------------------------------
    function automatic void log_mismatch(input string what);
        if (mismatches < 10)
            $display("MISMATCH: %s", what);
        mismatches++;
    endfunction

    always @(posedge i_clk) begin : result_monitor
        forb_pkg::t_result e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (result_q.size() == 0) begin
                    log_mismatch($sformatf(
                        "unexpected result value=%h has=%b end=%b st=%0d",
                        o_value, o_has_value, o_block_end, o_status));
                end else begin
                    e = result_q.pop_front();
                    n_results++;
                    if (e.has_value) n_values++;
                    if (e.block_end) n_blocks++;
                    if (e.status == forb_pkg::ST_SKIPPED) n_skipped++;
                    if (e.status == forb_pkg::ST_TRUNCATED) n_truncated++;
                    if (o_value !== e.value || o_has_value !== e.has_value ||
                        o_block_end !== e.block_end || o_status !== e.status)
                        log_mismatch($sformatf({
                            "result %0d exp value=%h has=%b end=%b st=%0d, ",
                            "got value=%h has=%b end=%b st=%0d"},
                            n_results, e.value, e.has_value, e.block_end, e.status,
                            o_value, o_has_value, o_block_end, o_status));
                end
            end
            i_stall <= rx_hold || ($urandom_range(99) < stall_pct);
        end
    end

    // Long receiver hold-off, so the block backs up and stalls its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Global guard
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [31:0] make_header(input bit comp, input bit has_base,
                                                input int wb, input int len);
        return {comp, has_base, 3'(wb - 1), 4'($urandom), 23'(len)};
    endfunction

    task automatic push_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_header(input logic [31:0] h);
        for (int i = 0; i < 4; i++)
            push_byte(h[8*i +: 8]);
    endtask

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            push_byte(rand_byte());
    endtask

    // Header, base (if flagged, sized for the current width) and body bytes
    task automatic push_block(input bit comp, input bit has_base, input int wb,
                              input int body);
        int bsz;
        bsz = has_base ? (wide ? 8 : 4) : 0;
        push_header(make_header(comp, has_base, wb, body + bsz));
        push_random(bsz + body);
    endtask

    // Mostly well-formed blocks, with skipped, truncated and short ones mixed in
    task automatic random_blocks(input int target);
        int start;
        int pick;
        int wb;
        int bsz;
        start = bytes_queued;
        while (bytes_queued - start < target) begin
            pick = $urandom_range(99);
            wb   = $urandom_range(8, 1);
            bsz  = wide ? 8 : 4;
            if (pick < 10) begin
                push_block(1'b1, 1'($urandom_range(1)), wb, $urandom_range(6));
            end else if (pick < 18) begin
                if (wb == 1) wb = 2;
                push_block(1'b0, 1'($urandom_range(1)), wb,
                           wb * $urandom_range(2) + $urandom_range(wb - 1, 1));
            end else if (pick < 24) begin
                push_header(make_header(1'($urandom_range(1)), 1'b1, wb,
                                        $urandom_range(bsz)));
                push_random(bsz);
            end else begin
                push_block(1'b0, 1'($urandom_range(1)), wb, wb * $urandom_range(5, 1));
            end
        end
    endtask

    // Wait until every byte is taken and every result is back, then settle
    task automatic drain();
        int n;
        n = 0;
        while ((byte_q.size() != 0 || i_valid || result_q.size() != 0) &&
               n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_width(input bit w, input int send_idle, input int rx_stall);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        wide = w;
        n_width_sets++;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        idle_pct  = send_idle;
        stall_pct = rx_stall;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 64-bit values, no idling; directed cases first
        write_width(1'b1, 0, 0);
        push_header(make_header(1'b0, 1'b0, 1, 0));     // empty raw block
        push_header(make_header(1'b1, 1'b0, 1, 0));     // empty compressed block
        push_block(1'b1, 1'b0, 1, 2);                   // compressed body skipped
        push_header(make_header(1'b0, 1'b0, 2, 1));     // value cut short
        push_byte(8'hFF);
        push_header(make_header(1'b0, 1'b1, 1, 3));     // length shorter than base
        push_random(8);
        push_header(make_header(1'b0, 1'b0, 1, 2));     // byte extremes
        push_byte(8'h00);
        push_byte(8'hFF);
        random_blocks(50);
        drain();

        // 32-bit values, sender mostly idle
        write_width(1'b0, 79, 0);
        random_blocks(50);
        drain();

        // 64-bit values, receiver mostly stalling; end inside a base
        write_width(1'b1, 0, 79);
        random_blocks(50);
        push_header(make_header(1'b0, 1'b1, 1, 10));
        push_random(3);
        drain();

        // 32-bit values while that base is open, both sides idling
        write_width(1'b0, 23, 23);
        push_random(3);
        random_blocks(50);
        drain();

        // 64-bit values under a long receiver hold-off, then a block left open
        write_width(1'b1, 0, 0);
        hold_go = 1'b1;
        random_blocks(80);
        push_header(make_header(1'b0, 1'b0, $urandom_range(8, 1), 23'h7F_FFFF));
        push_random(24);
        drain();

        if (result_q.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", result_q.size()));

        $display("Decoded %0d stream bytes into %0d results: %0d values, %0d blocks closed",
                 bytes_taken, n_results, n_values, n_blocks);
        $display("(%0d skipped, %0d truncated) across %0d width settings,",
                 n_skipped, n_truncated, n_width_sets);
        $display("with idle, stall and hold-off mixes");
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/forb_pkg.sv
rtl/forb_step.sv
rtl/frame_of_reference_byte_unpack_decoder.sv
sim/tb_top.sv
